@@ rtl/gcp_pkg.sv @@
package gcp_pkg;

    localparam int CORDIC_STAGES = 16;

    // Angles: degrees times 65536, wide enough for one full turn either way
    localparam int ANG_W = 26;
    typedef logic signed [ANG_W-1:0] t_ang;

    localparam t_ang QUARTER_TURN = t_ang'(5898240);
    localparam t_ang HALF_TURN    = t_ang'(11796480);
    localparam t_ang FULL_TURN    = t_ang'(23592960);

    // Sines and cosines in Q30
    localparam int CS_W = 32;
    typedef logic signed [CS_W-1:0] t_cs;
    localparam t_cs CORDIC_GAIN = t_cs'(652032874);
    localparam t_cs ONE_Q30     = t_cs'(1073741824);

    // Square root of 2^60 - c^2, one result bit per stage
    localparam int RAD_W      = 62;
    localparam int SQRT_TOP   = 60;
    localparam int SQRT_STEPS = SQRT_TOP / 2 + 1;
    localparam int ROOT_W     = 31;

    typedef struct packed {
        logic [RAD_W-1:0] rem;
        logic [RAD_W-1:0] root;
    } t_sqrt;

    // Clamped arc angle, 0 to 180 degrees
    localparam int ARC_W = 24;

    localparam int FACT_W = 23;
    localparam int PROD_W = ARC_W + FACT_W;
    localparam int SEP_W  = 19;
    localparam int GAP_W  = 16;
    localparam logic [SEP_W-1:0] SEP_MAX = SEP_W'(327679);

    // Register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_UNIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_THR   = 2'd2;

    // Unit codes
    localparam logic [1:0] UNIT_MILES    = 2'd0;
    localparam logic [1:0] UNIT_KM       = 2'd1;
    localparam logic [1:0] UNIT_NAUTICAL = 2'd2;

    // Stages between input and the distance product
    localparam int SIDE_DEPTH = 2 * CORDIC_STAGES + 39;

    function automatic t_ang atan_q16(input logic [4:0] idx);
        t_ang res;
        unique case (idx)
            5'd0:  res = t_ang'(2949120);
            5'd1:  res = t_ang'(1740967);
            5'd2:  res = t_ang'(919879);
            5'd3:  res = t_ang'(466945);
            5'd4:  res = t_ang'(234379);
            5'd5:  res = t_ang'(117304);
            5'd6:  res = t_ang'(58666);
            5'd7:  res = t_ang'(29335);
            5'd8:  res = t_ang'(14668);
            5'd9:  res = t_ang'(7334);
            5'd10: res = t_ang'(3667);
            5'd11: res = t_ang'(1833);
            5'd12: res = t_ang'(917);
            5'd13: res = t_ang'(458);
            5'd14: res = t_ang'(229);
            5'd15: res = t_ang'(115);
            5'd16: res = t_ang'(57);
            5'd17: res = t_ang'(29);
            5'd18: res = t_ang'(14);
            5'd19: res = t_ang'(7);
            5'd20: res = t_ang'(4);
            5'd21: res = t_ang'(2);
            5'd22: res = t_ang'(1);
            default: res = '0;
        endcase
        return res;
    endfunction

    function automatic t_sqrt sqrt_step(input t_sqrt st, input logic [RAD_W-1:0] bit_w);
        t_sqrt res;
        logic [RAD_W-1:0] trial;
        trial = st.root + bit_w;
        if (st.rem >= trial) begin
            res.rem  = st.rem - trial;
            res.root = (st.root >> 1) + bit_w;
        end else begin
            res.rem  = st.rem;
            res.root = st.root >> 1;
        end
        return res;
    endfunction

    function automatic logic [FACT_W-1:0] unit_factor(input logic [1:0] unit);
        logic [FACT_W-1:0] res;
        unique case (unit)
            UNIT_KM:       res = FACT_W'(7286920);
            UNIT_NAUTICAL: res = FACT_W'(3932013);
            default:       res = FACT_W'(4527882);
        endcase
        return res;
    endfunction

endpackage

@@ rtl/gcp_sincos.sv @@
module gcp_sincos import gcp_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_ang i_angle,
    output t_cs  o_sin,
    output t_cs  o_cos
);

    t_ang w_red;
    t_ang w_fold;
    logic w_neg;

    t_cs  r_x   [0:CORDIC_STAGES];
    t_cs  r_y   [0:CORDIC_STAGES];
    t_ang r_z   [0:CORDIC_STAGES];
    logic r_neg [0:CORDIC_STAGES];

    // Reduce into (-180,180], then fold into [-90,90] and remember the sign flip
    always_comb begin
        w_red = i_angle;
        if (i_angle > HALF_TURN) begin
            w_red = i_angle - FULL_TURN;
        end else if (i_angle <= -HALF_TURN) begin
            w_red = i_angle + FULL_TURN;
        end
        w_fold = w_red;
        w_neg  = 1'b0;
        if (w_red > QUARTER_TURN) begin
            w_fold = w_red - HALF_TURN;
            w_neg  = 1'b1;
        end else if (w_red < -QUARTER_TURN) begin
            w_fold = w_red + HALF_TURN;
            w_neg  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= CORDIC_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= w_fold;
            r_neg[0] <= w_neg;
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[k] >= 0) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - atan_q16(5'(k));
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + atan_q16(5'(k));
                end
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    assign o_sin = r_neg[CORDIC_STAGES] ? -r_y[CORDIC_STAGES] : r_y[CORDIC_STAGES];
    assign o_cos = r_neg[CORDIC_STAGES] ? -r_x[CORDIC_STAGES] : r_x[CORDIC_STAGES];

endmodule

@@ rtl/gcp_isqrt.sv @@
module gcp_isqrt import gcp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [RAD_W-1:0]  i_rad,
    output logic [ROOT_W-1:0] o_root
);

    t_sqrt r_st [0:SQRT_STEPS-1];
    t_sqrt w_in;

    assign w_in.rem  = i_rad;
    assign w_in.root = '0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= sqrt_step(w_in, RAD_W'(1) << SQRT_TOP);
        end
    end

    for (genvar k = 1; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [RAD_W-1:0] BIT_K = RAD_W'(1) << (SQRT_TOP - 2 * k);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= sqrt_step(r_st[k-1], BIT_K);
            end
        end
    end

    assign o_root = r_st[SQRT_STEPS-1].root[ROOT_W-1:0];

endmodule

@@ rtl/gcp_acos.sv @@
module gcp_acos import gcp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  t_cs               i_c,
    input  logic [ROOT_W-1:0] i_s,
    output logic [ARC_W-1:0]  o_arc
);

    typedef logic signed [CS_W:0] t_vec;

    t_vec r_x [0:CORDIC_STAGES];
    t_vec r_y [0:CORDIC_STAGES];
    t_ang r_z [0:CORDIC_STAGES];
    logic [ARC_W-1:0] r_arc;

    // Turn a vector in the left half plane by -90 degrees first
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_c < 0) begin
                r_x[0] <= t_vec'({1'b0, i_s});
                r_y[0] <= -t_vec'(i_c);
                r_z[0] <= QUARTER_TURN;
            end else begin
                r_x[0] <= t_vec'(i_c);
                r_y[0] <= t_vec'({1'b0, i_s});
                r_z[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[k] > 0) begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + atan_q16(5'(k));
                end else begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - atan_q16(5'(k));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_z[CORDIC_STAGES] < 0) begin
                r_arc <= '0;
            end else if (r_z[CORDIC_STAGES] > HALF_TURN) begin
                r_arc <= HALF_TURN[ARC_W-1:0];
            end else begin
                r_arc <= r_z[CORDIC_STAGES][ARC_W-1:0];
            end
        end
    end

    assign o_arc = r_arc;

endmodule

@@ rtl/great_circle_proximity_check.sv @@
// Sin/cos, square root and acos are unrolled, so the datapath is fully pipelined.
// Throughput: one transaction per cycle while the skid register is empty; while it
// holds a result, o_in_stall is raised and the whole pipeline holds.
// A skid register behind the output register takes one result while the output stalls.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets distance_unit to
// kilometres and both thresholds to zero.
module great_circle_proximity_check import gcp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [23:0]      i_latitude_a,
    input  logic signed [24:0]      i_longitude_a,
    input  logic signed [15:0]      i_magnitude_a,
    input  logic signed [23:0]      i_latitude_b,
    input  logic signed [24:0]      i_longitude_b,
    input  logic signed [15:0]      i_magnitude_b,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [SEP_W-1:0]        o_separation,
    output logic [GAP_W-1:0]        o_magnitude_gap,
    output logic                    o_near_match
);

    typedef struct packed {
        logic             valid;
        logic             same;
        logic [GAP_W-1:0] gap;
    } t_side;

    logic [1:0]        r_unit;
    logic [SEP_W-1:0]  r_dist_thr;
    logic [GAP_W-1:0]  r_mag_thr;

    logic en;
    t_ang w_lat_a, w_lat_b, w_dlon;
    logic signed [GAP_W:0] w_mdiff;
    logic [GAP_W:0]        w_mabs;
    t_side w_side;
    t_side r_sb [0:SIDE_DEPTH-1];

    t_cs w_sa, w_ca, w_sb, w_cb, w_sd, w_cd;
    logic signed [63:0] w_mul_s, w_mul_c, w_mul_d, w_sq;
    t_cs r_psa, r_pcc, r_cd, r_psa2, r_pdd, r_term, r_term_d;
    logic signed [CS_W:0] w_sum;
    t_cs w_term;
    logic [RAD_W-1:0]  r_rad;
    t_cs r_cdl [0:SQRT_STEPS-1];
    logic [ROOT_W-1:0] w_root;
    logic [ARC_W-1:0]  w_arc;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W:0]   w_round;
    logic [PROD_W-28:0] w_sep_full;
    logic [SEP_W-1:0]  w_sep;

    logic              r_fin_valid, r_fin_match;
    logic [SEP_W-1:0]  r_fin_sep;
    logic [GAP_W-1:0]  r_fin_gap;

    logic              r_out_valid, r_out_match;
    logic [SEP_W-1:0]  r_out_sep;
    logic [GAP_W-1:0]  r_out_gap;
    logic              r_skid_valid, r_skid_match;
    logic [SEP_W-1:0]  r_skid_sep;
    logic [GAP_W-1:0]  r_skid_gap;
    logic              out_ready;

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit     <= UNIT_KM;
            r_dist_thr <= '0;
            r_mag_thr  <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                REG_DIST_UNIT: r_unit     <= i_cfg_wdata[1:0];
                REG_DIST_THR:  r_dist_thr <= i_cfg_wdata[SEP_W-1:0];
                REG_MAG_THR:   r_mag_thr  <= i_cfg_wdata[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless the skid register holds a result
    assign en         = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    assign w_lat_a = t_ang'(i_latitude_a);
    assign w_lat_b = t_ang'(i_latitude_b);
    assign w_dlon  = t_ang'(i_longitude_a) - t_ang'(i_longitude_b);

    assign w_mdiff = (GAP_W+1)'(i_magnitude_a) - (GAP_W+1)'(i_magnitude_b);
    assign w_mabs  = w_mdiff < 0 ? (GAP_W+1)'(-w_mdiff) : (GAP_W+1)'(w_mdiff);

    assign w_side.valid = i_in_valid;
    assign w_side.same  = (i_latitude_a == i_latitude_b) && (i_longitude_a == i_longitude_b);
    assign w_side.gap   = w_mabs[GAP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SIDE_DEPTH; k++) begin
                r_sb[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_sb[0] <= w_side;
            for (int k = 1; k < SIDE_DEPTH; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    gcp_sincos u_sc_a (.i_clk(i_clk), .i_en(en), .i_angle(w_lat_a), .o_sin(w_sa), .o_cos(w_ca));
    gcp_sincos u_sc_b (.i_clk(i_clk), .i_en(en), .i_angle(w_lat_b), .o_sin(w_sb), .o_cos(w_cb));
    gcp_sincos u_sc_d (.i_clk(i_clk), .i_en(en), .i_angle(w_dlon),  .o_sin(w_sd), .o_cos(w_cd));

    // Products of Q30 values stay below 2^61, so bits 61..30 hold the shifted result
    assign w_mul_s = 64'(w_sa) * 64'(w_sb);
    assign w_mul_c = 64'(w_ca) * 64'(w_cb);
    assign w_mul_d = 64'(r_pcc) * 64'(r_cd);
    assign w_sum   = (CS_W+1)'(r_psa2) + (CS_W+1)'(r_pdd);

    always_comb begin
        if (w_sum > (CS_W+1)'(ONE_Q30)) begin
            w_term = ONE_Q30;
        end else if (w_sum < -(CS_W+1)'(ONE_Q30)) begin
            w_term = -ONE_Q30;
        end else begin
            w_term = w_sum[CS_W-1:0];
        end
    end

    assign w_sq = 64'(r_term) * 64'(r_term);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_psa    <= w_mul_s[61:30];
            r_pcc    <= w_mul_c[61:30];
            r_cd     <= w_cd;
            r_psa2   <= r_psa;
            r_pdd    <= w_mul_d[61:30];
            r_term   <= w_term;
            r_rad    <= (RAD_W'(1) << SQRT_TOP) - w_sq[RAD_W-1:0];
            r_term_d <= r_term;
            r_cdl[0] <= r_term_d;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_cdl[k] <= r_cdl[k-1];
            end
        end
    end

    gcp_isqrt u_isqrt (.i_clk(i_clk), .i_en(en), .i_rad(r_rad), .o_root(w_root));

    gcp_acos u_acos (
        .i_clk (i_clk),
        .i_en  (en),
        .i_c   (r_cdl[SQRT_STEPS-1]),
        .i_s   (w_root),
        .o_arc (w_arc)
    );

    assign w_round    = (PROD_W+1)'(r_prod) + ((PROD_W+1)'(1) << 27);
    assign w_sep_full = w_round[PROD_W:28];
    assign w_sep      = (w_sep_full > (PROD_W-27)'(SEP_MAX)) ? SEP_MAX : w_sep_full[SEP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= PROD_W'(w_arc) * PROD_W'(unit_factor(r_unit));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (en) begin
            r_fin_valid <= r_sb[SIDE_DEPTH-1].valid;
        end
    end

    // Identical positions give exactly zero
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fin_sep   <= r_sb[SIDE_DEPTH-1].same ? '0 : w_sep;
            r_fin_gap   <= r_sb[SIDE_DEPTH-1].gap;
            r_fin_match <= ((r_sb[SIDE_DEPTH-1].same ? '0 : w_sep) < r_dist_thr)
                           && (r_sb[SIDE_DEPTH-1].gap < r_mag_thr);
        end
    end

    // Output register with skid
    assign out_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= r_fin_valid;
            end
        end else if (r_fin_valid && en) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            if (r_skid_valid) begin
                r_out_sep   <= r_skid_sep;
                r_out_gap   <= r_skid_gap;
                r_out_match <= r_skid_match;
            end else begin
                r_out_sep   <= r_fin_sep;
                r_out_gap   <= r_fin_gap;
                r_out_match <= r_fin_match;
            end
        end else if (en) begin
            r_skid_sep   <= r_fin_sep;
            r_skid_gap   <= r_fin_gap;
            r_skid_match <= r_fin_match;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_separation    = r_out_sep;
    assign o_magnitude_gap = r_out_gap;
    assign o_near_match    = r_out_match;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the output register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(i_out_stall) && $past(r_out_valid))
        else $error("skid loaded without an output stall");

    a_sep_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_separation <= SEP_MAX))
        else $error("separation above saturation limit");

endmodule

@@ sim/testbench.sv @@
module testbench;
    import gcp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 2 * CORDIC_STAGES + 120;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int RANDOM_PHASES = 8;

    localparam longint Q_DEG = 64'sd5898240;
    localparam longint H_DEG = 64'sd11796480;
    localparam longint F_DEG = 64'sd23592960;

    typedef struct {
        logic [SEP_W-1:0] sep;
        logic [GAP_W-1:0] gap;
        logic             near;
    } t_outcome;

    typedef struct {
        logic signed [23:0] lat_a;
        logic signed [24:0] lon_a;
        logic signed [15:0] mag_a;
        logic signed [23:0] lat_b;
        logic signed [24:0] lon_b;
        logic signed [15:0] mag_b;
        bit                 typed;
        t_outcome           res;
    } t_pair;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic signed [23:0]    i_latitude_a = '0;
    logic signed [24:0]    i_longitude_a = '0;
    logic signed [15:0]    i_magnitude_a = '0;
    logic signed [23:0]    i_latitude_b = '0;
    logic signed [24:0]    i_longitude_b = '0;
    logic signed [15:0]    i_magnitude_b = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [SEP_W-1:0]      o_separation;
    logic [GAP_W-1:0]      o_magnitude_gap;
    logic                  o_near_match;

    great_circle_proximity_check u_top (.*);

    always #1 i_clk = ~i_clk;

    t_outcome pending_results[$];
    t_pair    directed_rows[$];
    int       error_count = 0;
    int       quiet_cycles = 0;
    bit       idle_enabled = 1'b1;

    logic [1:0]       unit_sel = UNIT_KM;
    logic [SEP_W-1:0] dist_limit = '0;
    logic [GAP_W-1:0] mag_limit = '0;

    longint arc_table[32] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    function automatic int rotations();
        return (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    endfunction

    function automatic void rotate_angle(input longint ang, output longint s,
                                         output longint c);
        longint x, y, z, dx, dy;
        bit     flip;
        x = 64'sd652032874;
        y = 0;
        flip = 1'b0;
        z = ang % F_DEG;
        if (z > H_DEG) z -= F_DEG;
        if (z <= -H_DEG) z += F_DEG;
        if (z > Q_DEG) begin
            z -= H_DEG;
            flip = 1'b1;
        end else if (z < -Q_DEG) begin
            z += H_DEG;
            flip = 1'b1;
        end
        for (int i = 0; i < rotations(); i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arc_table[i];
            end else begin
                x += dx; y -= dy; z += arc_table[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint unsigned int_root(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint central_angle(input longint c);
        longint x, y, z, dx, dy, s;
        s = longint'(int_root(longint'(64'sd1 <<< 60) - c * c));
        x = c;
        y = s;
        z = 0;
        if (x < 0) begin
            x = s; y = -c; z = Q_DEG;
        end
        for (int i = 0; i < rotations(); i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += arc_table[i];
            end else begin
                x -= dx; y += dy; z -= arc_table[i];
            end
        end
        if (z < 0) z = 0;
        if (z > H_DEG) z = H_DEG;
        return z;
    endfunction

    function automatic t_outcome predict_proximity(input t_pair p);
        t_outcome        o;
        longint          sa, ca, sb, cb, sd, cd, cos_term, d;
        longint unsigned sep, factor;
        sep = 0;
        if (p.lat_a != p.lat_b || p.lon_a != p.lon_b) begin
            rotate_angle(longint'(p.lat_a), sa, ca);
            rotate_angle(longint'(p.lat_b), sb, cb);
            rotate_angle(longint'(p.lon_a) - longint'(p.lon_b), sd, cd);
            cos_term = ((sa * sb) >>> 30) + ((((ca * cb) >>> 30) * cd) >>> 30);
            if (cos_term > 64'sd1073741824) cos_term = 64'sd1073741824;
            if (cos_term < -64'sd1073741824) cos_term = -64'sd1073741824;
            case (unit_sel)
                UNIT_KM:       factor = 7286920;
                UNIT_NAUTICAL: factor = 3932013;
                default:       factor = 4527882;
            endcase
            sep = (longint'(central_angle(cos_term)) * factor + (64'd1 << 27)) >> 28;
            if (sep > 327679) sep = 327679;
        end
        d = longint'(p.mag_a) - longint'(p.mag_b);
        o.sep  = sep[SEP_W-1:0];
        o.gap  = GAP_W'(d < 0 ? -d : d);
        o.near = (sep < dist_limit) && (o.gap < mag_limit);
        return o;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic add_row(input int la, input int oa, input int ma, input int lb,
                           input int ob, input int mb, input bit typed,
                           input int sep, input int gap, input bit near);
        t_pair p;
        p.lat_a = 24'(la); p.lon_a = 25'(oa); p.mag_a = 16'(ma);
        p.lat_b = 24'(lb); p.lon_b = 25'(ob); p.mag_b = 16'(mb);
        p.typed = typed;
        p.res.sep = SEP_W'(sep); p.res.gap = GAP_W'(gap); p.res.near = near;
        directed_rows.push_back(p);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_wen = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        case (idx)
            REG_DIST_UNIT: unit_sel = val[1:0];
            REG_DIST_THR:  dist_limit = val;
            REG_MAG_THR:   mag_limit = val[GAP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wen = 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic int draw_idle();
        return idle_enabled ? $urandom_range(0, 15) : 0;
    endfunction

    // Sit at a falling edge on entry and on exit
    task automatic send_pair(input t_pair p);
        int gap;
        gap = draw_idle();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_latitude_a = p.lat_a; i_longitude_a = p.lon_a; i_magnitude_a = p.mag_a;
        i_latitude_b = p.lat_b; i_longitude_b = p.lon_b; i_magnitude_b = p.mag_b;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(p.typed ? p.res : predict_proximity(p));
        @(negedge i_clk);
    endtask

    function automatic int pick_lat();
        return $signed($urandom_range(0, 11796480)) - 5898240;
    endfunction

    function automatic int pick_lon();
        return $signed($urandom_range(0, 23592960)) - 11796480;
    endfunction

    function automatic int nudge(input int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        int    mode;
        mode = $urandom_range(0, 9);
        p.typed = 1'b0;
        p.res = '{default: '0};
        p.mag_a = 16'($urandom);
        p.mag_b = ($urandom_range(0, 1) == 0) ? 16'(p.mag_a + nudge(600)) : 16'($urandom);
        case (mode)
            0: begin
                p.lat_a = 24'(pick_lat()); p.lon_a = 25'(pick_lon());
                p.lat_b = p.lat_a; p.lon_b = p.lon_a;
            end
            6, 7: begin
                p.lat_a = 24'(pick_lat()); p.lon_a = 25'(pick_lon());
                p.lat_b = 24'(pick_lat()); p.lon_b = 25'(pick_lon());
            end
            8: begin
                p.lat_a = 24'($urandom); p.lon_a = 25'($urandom);
                p.lat_b = 24'($urandom); p.lon_b = 25'($urandom);
            end
            9: begin
                // hug the poles and the date line
                p.lat_a = 24'(($urandom_range(0, 1) ? 5898240 : -5898240) + nudge(50000));
                p.lat_b = 24'(($urandom_range(0, 1) ? 5898240 : -5898240) + nudge(50000));
                p.lon_a = 25'(($urandom_range(0, 1) ? 11796480 : -11796480) + nudge(50000));
                p.lon_b = 25'(($urandom_range(0, 1) ? 11796480 : -11796480) + nudge(50000));
            end
            default: begin
                p.lat_a = 24'(pick_lat()); p.lon_a = 25'(pick_lon());
                p.lat_b = 24'(p.lat_a + nudge(20000));
                p.lon_b = 25'(p.lon_a + nudge(20000));
            end
        endcase
        return p;
    endfunction

    initial begin
        logic [1:0]       unit_next;
        logic [SEP_W-1:0] dthr_next;
        logic [GAP_W-1:0] mthr_next;

        add_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(8388607, -16777216, 32767, 8388607, -16777216, -32768, 1, 0, 65535, 0);
        add_row(-8388608, 16777215, -32768, -8388608, 16777215, -32768, 1, 0, 0, 0);
        add_row(5898240, 0, 0, -5898240, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 256, 0, 11796480, -256, 0, 0, 0, 0);
        add_row(0, -11796480, 0, 0, 11796480, 0, 0, 0, 0, 0);
        add_row(8388607, 16777215, 1, -8388608, -16777216, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 5898240, 0, 0, 0, 0, 0);
        add_row(5898240, 100, 0, 5898240, -3000000, 0, 0, 0, 0, 0);
        add_row(-5898240, 0, 32767, 0, 0, -32768, 0, 0, 0, 0);
        add_row(2949120, 11796480, 0, -2949120, -11796480, 0, 0, 0, 0, 0);
        add_row(1000000, -2000000, 0, 1000200, -2000300, 5, 0, 0, 0, 0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) send_pair(directed_rows[i]);
        i_in_valid = 1'b0;
        drain();

        // index three is unmapped: nothing may change
        write_reg(REG_SPARE, '1);
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            i_in_valid = 1'b0;
            drain();
            unit_next = 2'(ph);
            case (ph % 4)
                0: begin dthr_next = '0;      mthr_next = '0;      end
                1: begin dthr_next = SEP_MAX; mthr_next = 16'hFFFF; end
                2: begin dthr_next = '1;      mthr_next = GAP_W'($urandom); end
                default: begin
                    dthr_next = SEP_W'($urandom_range(0, 4000));
                    mthr_next = GAP_W'($urandom_range(0, 800));
                end
            endcase
            if (ph >= 4) dthr_next = SEP_W'($urandom_range(0, 3000));
            write_reg(REG_DIST_UNIT, unit_next);
            write_reg(REG_DIST_THR, dthr_next);
            write_reg(REG_MAG_THR, mthr_next);
            idle_enabled = (ph != 2);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) send_pair(random_pair());
        end
        i_in_valid = 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Receiver: hold off a random number of cycles, then take one transaction
    initial begin
        int       hold;
        t_outcome want;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            hold = draw_idle();
            if (hold > 0) begin
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            if (pending_results.size() == 0) begin
                report("unexpected result", 32'd0, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_separation !== want.sep)
                    report("separation", 32'(o_separation), 32'(want.sep));
                if (o_magnitude_gap !== want.gap)
                    report("magnitude_gap", 32'(o_magnitude_gap), 32'(want.gap));
                if (o_near_match !== want.near)
                    report("near_match", 32'(o_near_match), 32'(want.near));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
